[hdl/dspr_pkg.sv]
// ----------------------------------------------------------------------------
// dspr_pkg
// Shared types and constants for the data stack with pick and roll.
// ----------------------------------------------------------------------------
package dspr_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int DEFAULT_WIDTH = 32;

    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int CAP_W   = 7;
    localparam int DEPTH_W = 7;
    localparam int STAT_W  = 2;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(64);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_PICK = 2'd2,
        FUNC_ROLL = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROLL_CAP,
        S_ROLL_SHIFT,
        S_ROLL_LAST
    } t_state;

    // Result of one transaction on its way to the output register.
    typedef struct packed {
        logic               pick;
        logic [DEPTH_W-1:0] depth;
        t_status            status;
    } t_result;

endpackage

[hdl/data_stack_pick_roll_core.sv]
// ----------------------------------------------------------------------------
// data_stack_pick_roll_core
// LIFO word stack with push, pop, pick and roll held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: i_func selects
//   push, pop, pick or roll; i_push_value is the word to push; i_position
//   counts from the top (1 is the top) for pick and roll.
//   Output channel (o_out_valid / i_out_ready) returns one result per request:
//   the picked word (zero otherwise), the depth after the request and a status.
//   Capacity is written through i_cfg_wr_en / i_cfg_wr_data while idle.
// Throughput and roll:
//   Push, pop, pick and any refused or trivial roll: the result passes through
//   the read stage and the output register, and a new transaction can enter
//   every cycle while the output is not stalled. The read stage covers the read
//   latency of the stack RAM, which every result path shares. A roll of n
//   elements walks the RAM one entry per cycle (one read and one write port):
//   o_in_ready stays low until the last write, which also loads the read stage.
// Reset:
//   Depth goes to zero and capacity to 64; RAM contents are not cleared, as
//   only entries below the depth are ever read.
// Stall:
//   A result waits in the output register; the one behind it waits in the
//   read stage, and the input is held off until that stage can drain.
// ----------------------------------------------------------------------------
module data_stack_pick_roll_core #(
    parameter int DEPTH = dspr_pkg::DEFAULT_DEPTH,
    parameter int WIDTH = dspr_pkg::DEFAULT_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [dspr_pkg::CAP_W-1:0]    i_cfg_wr_data,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dspr_pkg::FUNC_W-1:0]   i_func,
    input  logic [dspr_pkg::VALUE_W-1:0]  i_push_value,
    input  logic [dspr_pkg::POS_W-1:0]    i_position,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dspr_pkg::VALUE_W-1:0]  o_read_value,
    output logic [dspr_pkg::DEPTH_W-1:0]  o_depth_count,
    output logic [dspr_pkg::STAT_W-1:0]   o_status
);
    import dspr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // common width for comparing depth, capacity and position
    localparam int MW = ((CW > POS_W) ? CW : POS_W) + 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CAP_W-1:0]     r_capacity;
    logic [AW-1:0]        r_ptr, n_ptr;
    logic [WIDTH-1:0]     r_moved, n_moved;

    logic                 r_s1_valid;
    t_result              r_s1;

    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_value;
    logic [DEPTH_W-1:0]   r_out_depth;
    t_status              r_out_status;

    // ------------------------------------------------------------------
    // RAM port controls
    // ------------------------------------------------------------------
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WIDTH-1:0]     wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WIDTH-1:0]     rd_data;

    logic                 load_s1;
    t_result              s1_new;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic in_fire;
    logic s1_adv;
    logic s1_free;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign s1_free    = !r_s1_valid || s1_adv;
    assign o_in_ready = (r_state == S_IDLE) && s1_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    t_func         func;
    logic [MW-1:0] count_x;
    logic [MW-1:0] pos_x;
    logic [MW-1:0] cap_x;
    logic          push_ok;
    logic          pop_ok;
    logic          pos_ok;
    logic          roll_run;
    logic [AW-1:0] sel_addr;
    logic [AW-1:0] top1;
    logic [AW-1:0] top2;

    always_comb begin
        func     = t_func'(i_func);
        count_x  = MW'(r_count);
        pos_x    = MW'(i_position);
        cap_x    = MW'(r_capacity);
        push_ok  = (count_x < cap_x) && (count_x < MW'(DEPTH));
        pop_ok   = (r_count != '0);
        pos_ok   = (pos_x != '0) && (pos_x <= count_x);
        // a roll of one element or none is a no-op
        roll_run = (pos_x >= MW'(2)) && (pos_x <= count_x);
        sel_addr = AW'(count_x - pos_x);
        top1     = AW'(count_x - MW'(1));
        top2     = AW'(count_x - MW'(2));
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (func == FUNC_ROLL) && roll_run) begin
                    n_state = S_ROLL_CAP;
                end
            end
            S_ROLL_CAP: begin
                n_state = S_ROLL_SHIFT;
            end
            S_ROLL_SHIFT: begin
                if (r_ptr == top2) begin
                    n_state = S_ROLL_LAST;
                end
            end
            S_ROLL_LAST: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM control
    // ------------------------------------------------------------------
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = '0;
        load_s1 = 1'b0;
        s1_new  = '{pick: 1'b0, depth: DEPTH_W'(r_count), status: ST_OK};
        n_count = r_count;
        n_ptr   = r_ptr;
        n_moved = r_moved;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    load_s1 = 1'b1;
                    unique case (func)
                        FUNC_PUSH: begin
                            if (push_ok) begin
                                wr_en        = 1'b1;
                                wr_addr      = AW'(r_count);
                                wr_data      = WIDTH'(i_push_value);
                                n_count      = r_count + CW'(1);
                                s1_new.depth = DEPTH_W'(n_count);
                            end else begin
                                s1_new.status = ST_OVERFLOW;
                            end
                        end
                        FUNC_POP: begin
                            if (pop_ok) begin
                                n_count      = r_count - CW'(1);
                                s1_new.depth = DEPTH_W'(n_count);
                            end else begin
                                s1_new.status = ST_RANGE;
                            end
                        end
                        FUNC_PICK: begin
                            if (pos_ok) begin
                                rd_en       = 1'b1;
                                rd_addr     = sel_addr;
                                s1_new.pick = 1'b1;
                            end else begin
                                s1_new.status = ST_RANGE;
                            end
                        end
                        FUNC_ROLL: begin
                            if (roll_run) begin
                                // fetch the element to move; result follows the walk
                                rd_en   = 1'b1;
                                rd_addr = sel_addr;
                                n_ptr   = sel_addr;
                                load_s1 = 1'b0;
                            end else if (pos_x >= MW'(2)) begin
                                s1_new.status = ST_RANGE;
                            end
                        end
                        default: begin
                            s1_new.status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_ROLL_CAP: begin
                n_moved = rd_data;
                rd_en   = 1'b1;
                rd_addr = r_ptr + AW'(1);
            end
            S_ROLL_SHIFT: begin
                // shift the entry above down by one place
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                wr_data = rd_data;
                if (r_ptr != top2) begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr + AW'(2);
                    n_ptr   = r_ptr + AW'(1);
                end
            end
            S_ROLL_LAST: begin
                wr_en   = 1'b1;
                wr_addr = top1;
                wr_data = r_moved;
                load_s1 = 1'b1;
            end
            default: begin
                load_s1 = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stack RAM
    // ------------------------------------------------------------------
    dspr_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= CAPACITY_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (load_s1) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_moved <= n_moved;
        if (load_s1) begin
            r_s1 <= s1_new;
        end
        // the RAM read for a pick lands while the request sits in the read stage
        if (s1_adv) begin
            r_out_value  <= r_s1.pick ? VALUE_W'(rd_data) : '0;
            r_out_depth  <= r_s1.depth;
            r_out_status <= r_s1.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_value;
    assign o_depth_count = r_out_depth;
    assign o_status      = r_out_status;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        MW'(r_count) <= MW'(DEPTH))
        else $error("stack depth beyond RAM depth");

    a_s1_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_s1 |-> s1_free)
        else $error("read stage overwritten while holding a result");

    a_ram_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("RAM read and write hit the same entry");

    a_roll_keeps_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_count == $past(r_count)))
        else $error("depth changed during a roll");

    a_pick_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.pick) |-> (r_s1.status == ST_OK))
        else $error("pick data flagged on a failed request");
`endif

endmodule

[hdl/dspr_ram.sv]
// ----------------------------------------------------------------------------
// dspr_ram
// Simple dual-port stack memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dspr_ram #(
    parameter int DEPTH = dspr_pkg::DEFAULT_DEPTH,
    parameter int WIDTH = dspr_pkg::DEFAULT_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    import dspr_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
